// ===== sv/disjoint_set_union_engine_defines.svh =====
`ifndef DISJOINT_SET_UNION_ENGINE_DEFINES_SVH
`define DISJOINT_SET_UNION_ENGINE_DEFINES_SVH

// check a condition in the same cycle as its trigger
`define DSU_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("dsu check failed: same-cycle rule");

// check a condition in the cycle after its trigger
`define DSU_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("dsu check failed: next-cycle rule");

`endif

// ===== sv/dsu_pkg.sv =====
package dsu_pkg;

    localparam int MAX_ELEMENTS = 1024;
    localparam int IDX_W        = $clog2(MAX_ELEMENTS);
    localparam int CNT_W        = $clog2(MAX_ELEMENTS + 1);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_FIND,
        S_COMP,
        S_START,
        S_SZA,
        S_SZB,
        S_LINK,
        S_DONE
    } t_state;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        logic [IDX_W-1:0] wdata;
        logic [IDX_W-1:0] raddr;
    } t_par_port;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        logic [CNT_W-1:0] wdata;
        logic [IDX_W-1:0] raddr;
    } t_size_port;

endpackage

// ===== sv/dsu_ram.sv =====
module dsu_ram #(
    parameter int DATA_W = 8,
    parameter int ADDR_W = 4
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [2**ADDR_W];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/dsu_ctrl.sv =====
module dsu_ctrl (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic [dsu_pkg::IDX_W-1:0]  i_first_item,
    input  logic [dsu_pkg::IDX_W-1:0]  i_second_item,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic                       o_merged,
    output logic [dsu_pkg::IDX_W-1:0]  o_surviving_root,
    output logic [dsu_pkg::CNT_W-1:0]  o_sets_left,
    output logic                       o_index_error,
    input  logic                       i_cfg_valid,
    input  logic [dsu_pkg::CNT_W-1:0]  i_cfg_element_count,
    output dsu_pkg::t_par_port         o_par,
    input  logic [dsu_pkg::IDX_W-1:0]  i_par_rdata,
    output dsu_pkg::t_size_port        o_size,
    input  logic [dsu_pkg::CNT_W-1:0]  i_size_rdata
);
    import dsu_pkg::*;

    function automatic logic [CNT_W-1:0] clamp_count(input logic [CNT_W-1:0] v);
        logic [CNT_W-1:0] c;
        c = v;
        if (v == '0) begin
            c = CNT_W'(1);
        end else if (v > CNT_W'(MAX_ELEMENTS)) begin
            c = CNT_W'(MAX_ELEMENTS);
        end
        return c;
    endfunction

    t_state           r_state, n_state;
    logic [IDX_W-1:0] r_clr, n_clr;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [CNT_W-1:0] r_sets, n_sets;
    logic [IDX_W-1:0] r_b, n_b;
    logic [IDX_W-1:0] r_cur, n_cur;
    logic [IDX_W-1:0] r_start, n_start;
    logic [IDX_W-1:0] r_root, n_root;
    logic [IDX_W-1:0] r_root_a, n_root_a;
    logic             r_phase, n_phase;
    logic [CNT_W-1:0] r_size_a, n_size_a;
    logic             r_res_merged, n_res_merged;
    logic [IDX_W-1:0] r_res_root, n_res_root;
    logic [CNT_W-1:0] r_res_sets, n_res_sets;
    logic             r_res_err, n_res_err;
    logic             r_o_valid, n_o_valid;
    logic             r_o_merged, n_o_merged;
    logic [IDX_W-1:0] r_o_root, n_o_root;
    logic [CNT_W-1:0] r_o_sets, n_o_sets;
    logic             r_o_err, n_o_err;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_clr     <= '0;
            r_cnt     <= clamp_count(CNT_W'(MAX_ELEMENTS));
            r_sets    <= clamp_count(CNT_W'(MAX_ELEMENTS));
            r_phase   <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_clr     <= n_clr;
            r_cnt     <= n_cnt;
            r_sets    <= n_sets;
            r_phase   <= n_phase;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_b          <= n_b;
        r_cur        <= n_cur;
        r_start      <= n_start;
        r_root       <= n_root;
        r_root_a     <= n_root_a;
        r_size_a     <= n_size_a;
        r_res_merged <= n_res_merged;
        r_res_root   <= n_res_root;
        r_res_sets   <= n_res_sets;
        r_res_err    <= n_res_err;
        r_o_merged   <= n_o_merged;
        r_o_root     <= n_o_root;
        r_o_sets     <= n_o_sets;
        r_o_err      <= n_o_err;
    end

    always_comb begin
        logic             v_end;
        logic [IDX_W-1:0] v_root;
        logic [IDX_W-1:0] v_big;
        logic [IDX_W-1:0] v_small;
        logic [CNT_W-1:0] v_set_n;

        n_state      = r_state;
        n_clr        = r_clr;
        n_cnt        = r_cnt;
        n_sets       = r_sets;
        n_b          = r_b;
        n_cur        = r_cur;
        n_start      = r_start;
        n_root       = r_root;
        n_root_a     = r_root_a;
        n_phase      = r_phase;
        n_size_a     = r_size_a;
        n_res_merged = r_res_merged;
        n_res_root   = r_res_root;
        n_res_sets   = r_res_sets;
        n_res_err    = r_res_err;
        n_o_valid    = r_o_valid;
        n_o_merged   = r_o_merged;
        n_o_root     = r_o_root;
        n_o_sets     = r_o_sets;
        n_o_err      = r_o_err;
        o_in_ready   = 1'b0;
        o_par        = '{we: 1'b0, waddr: r_cur, wdata: r_root, raddr: r_cur};
        o_size       = '{we: 1'b0, waddr: r_root, wdata: '0, raddr: r_root};
        v_end        = 1'b0;
        v_root       = r_root;
        v_big        = r_root_a;
        v_small      = r_root;
        v_set_n      = r_sets;

        if (r_o_valid && i_out_ready) begin
            n_o_valid = 1'b0;
        end

        case (r_state)
            S_CLEAR: begin
                o_par  = '{we: 1'b1, waddr: r_clr, wdata: r_clr, raddr: r_clr};
                o_size = '{we: 1'b1, waddr: r_clr, wdata: CNT_W'(1), raddr: r_clr};
                n_clr  = r_clr + 1'b1;
                if (r_clr == IDX_W'(MAX_ELEMENTS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_par.raddr = i_first_item;
                if (i_in_valid) begin
                    n_b     = i_second_item;
                    n_cur   = i_first_item;
                    n_start = i_first_item;
                    n_phase = 1'b0;
                    if ({1'b0, i_first_item} >= r_cnt || {1'b0, i_second_item} >= r_cnt) begin
                        n_res_merged = 1'b0;
                        n_res_root   = '0;
                        n_res_sets   = r_sets;
                        n_res_err    = 1'b1;
                        n_state      = S_DONE;
                    end else begin
                        n_state = S_FIND;
                    end
                end
            end
            S_FIND: begin
                if (i_par_rdata == r_cur) begin
                    v_root = r_cur;
                    n_root = r_cur;
                    if (r_start == r_cur) begin
                        v_end = 1'b1;
                    end else begin
                        n_cur       = r_start;
                        o_par.raddr = r_start;
                        n_state     = S_COMP;
                    end
                end else begin
                    n_cur       = i_par_rdata;
                    o_par.raddr = i_par_rdata;
                end
            end
            S_COMP: begin
                o_par.we = 1'b1;
                if (i_par_rdata == r_root) begin
                    v_end = 1'b1;
                end else begin
                    n_cur       = i_par_rdata;
                    o_par.raddr = i_par_rdata;
                end
            end
            S_START: begin
                n_state = S_FIND;
            end
            S_SZA: begin
                o_size.raddr = r_root_a;
                n_state      = S_SZB;
            end
            S_SZB: begin
                n_size_a = i_size_rdata;
                n_state  = S_LINK;
            end
            S_LINK: begin
                if (r_size_a < i_size_rdata) begin
                    v_big   = r_root;
                    v_small = r_root_a;
                end
                if (r_sets > CNT_W'(1)) begin
                    v_set_n = r_sets - 1'b1;
                end
                o_par        = '{we: 1'b1, waddr: v_small, wdata: v_big, raddr: v_small};
                o_size       = '{we: 1'b1, waddr: v_big, wdata: r_size_a + i_size_rdata,
                                 raddr: v_big};
                n_sets       = v_set_n;
                n_res_merged = 1'b1;
                n_res_root   = v_big;
                n_res_sets   = v_set_n;
                n_res_err    = 1'b0;
                n_state      = S_DONE;
            end
            S_DONE: begin
                if (!r_o_valid || i_out_ready) begin
                    n_o_valid  = 1'b1;
                    n_o_merged = r_res_merged;
                    n_o_root   = r_res_root;
                    n_o_sets   = r_res_sets;
                    n_o_err    = r_res_err;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (v_end) begin
            if (!r_phase) begin
                n_root_a = v_root;
                n_phase  = 1'b1;
                n_cur    = r_b;
                n_start  = r_b;
                n_state  = S_START;
            end else if (v_root == r_root_a) begin
                n_res_merged = 1'b0;
                n_res_root   = v_root;
                n_res_sets   = r_sets;
                n_res_err    = 1'b0;
                n_state      = S_DONE;
            end else begin
                n_state = S_SZA;
            end
        end

        if (r_state == S_START) begin
            o_par.raddr = r_cur;
        end

        if (i_cfg_valid) begin
            n_cnt   = clamp_count(i_cfg_element_count);
            n_sets  = clamp_count(i_cfg_element_count);
            n_clr   = '0;
            n_state = S_CLEAR;
        end
    end

    assign o_out_valid      = r_o_valid;
    assign o_merged         = r_o_merged;
    assign o_surviving_root = r_o_root;
    assign o_sets_left      = r_o_sets;
    assign o_index_error    = r_o_err;

endmodule

// ===== sv/disjoint_set_union_engine.sv =====
// Union-find engine with union by size and path compression. After reset and after every
// write of element_count the forest is rebuilt by a clearing pass over every entry, during
// which no item is accepted; configuration writes are always taken. A join whose indexes
// are in range walks the parent links to the root of each item and relinks the nodes on
// the way back to that root; when the two roots differ it reads both set sizes and links
// the smaller set under the larger. An out-of-range join only reports an index error.
// The parent memory serves one link read per cycle in both the walk and the relink pass.
// A finished result sits in an output register, so the next item can start while it waits.
module disjoint_set_union_engine (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic [dsu_pkg::IDX_W-1:0]  i_first_item,
    input  logic [dsu_pkg::IDX_W-1:0]  i_second_item,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic                       o_merged,
    output logic [dsu_pkg::IDX_W-1:0]  o_surviving_root,
    output logic [dsu_pkg::CNT_W-1:0]  o_sets_left,
    output logic                       o_index_error,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [dsu_pkg::CNT_W-1:0]  i_cfg_element_count
);
    import dsu_pkg::*;

    t_par_port        par;
    t_size_port       size;
    logic [IDX_W-1:0] par_rdata;
    logic [CNT_W-1:0] size_rdata;

    assign o_cfg_ready = 1'b1;

    dsu_ctrl u_ctrl (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in_valid          (i_in_valid),
        .o_in_ready          (o_in_ready),
        .i_first_item        (i_first_item),
        .i_second_item       (i_second_item),
        .o_out_valid         (o_out_valid),
        .i_out_ready         (i_out_ready),
        .o_merged            (o_merged),
        .o_surviving_root    (o_surviving_root),
        .o_sets_left         (o_sets_left),
        .o_index_error       (o_index_error),
        .i_cfg_valid         (i_cfg_valid),
        .i_cfg_element_count (i_cfg_element_count),
        .o_par               (par),
        .i_par_rdata         (par_rdata),
        .o_size              (size),
        .i_size_rdata        (size_rdata)
    );

    dsu_ram #(.DATA_W(IDX_W), .ADDR_W(IDX_W)) u_parent_ram (
        .i_clk   (i_clk),
        .i_we    (par.we),
        .i_waddr (par.waddr),
        .i_wdata (par.wdata),
        .i_raddr (par.raddr),
        .o_rdata (par_rdata)
    );

    dsu_ram #(.DATA_W(CNT_W), .ADDR_W(IDX_W)) u_size_ram (
        .i_clk   (i_clk),
        .i_we    (size.we),
        .i_waddr (size.waddr),
        .i_wdata (size.wdata),
        .i_raddr (size.raddr),
        .o_rdata (size_rdata)
    );

endmodule

// ===== sv/dsu_checker.sv =====
`include "disjoint_set_union_engine_defines.svh"

module dsu_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_in_valid,
    input logic                       o_in_ready,
    input logic                       o_out_valid,
    input logic                       i_out_ready,
    input logic                       o_merged,
    input logic [dsu_pkg::IDX_W-1:0]  o_surviving_root,
    input logic [dsu_pkg::CNT_W-1:0]  o_sets_left,
    input logic                       o_index_error,
    input logic                       i_cfg_valid,
    input logic                       o_cfg_ready
);
    import dsu_pkg::*;

    logic                   out_wait;
    logic                   in_take;
    logic                   err_shape_ok;
    logic [IDX_W+CNT_W+1:0] res_bits;

    assign out_wait     = o_out_valid && !i_out_ready;
    assign in_take      = i_in_valid && o_in_ready;
    assign err_shape_ok = !o_merged && o_surviving_root == '0 && o_sets_left != '0;
    assign res_bits     = {o_merged, o_surviving_root, o_sets_left, o_index_error};

    `DSU_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, out_wait, o_out_valid && $stable(res_bits))
    `DSU_ASSERT_NOW(a_err_shape, i_clk, i_rst_n, o_out_valid && o_index_error, err_shape_ok)
    `DSU_ASSERT_NEXT(a_cfg_clears, i_clk, i_rst_n, i_cfg_valid && o_cfg_ready, !o_in_ready)
    `DSU_ASSERT_NEXT(a_one_at_a_time, i_clk, i_rst_n, in_take && !i_cfg_valid, !o_in_ready)

endmodule

bind disjoint_set_union_engine dsu_checker u_dsu_checker (.*);
